/* design/affine_trs_decompose_top_macros.svh */
// Assertion macros shared by the affine transform decomposition RTL.
`ifndef AFFINE_TRS_DECOMPOSE_TOP_MACROS_SVH
`define AFFINE_TRS_DECOMPOSE_TOP_MACROS_SVH

// The expression must never be true while out of reset.
`define ATD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ATD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/atd_pkg.sv */
// Shared constants and types of the affine transform decomposition block.
package atd_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NQ          = 30;
  localparam int N_AXIS      = 3;
  localparam int N_ELEM      = 9;
  localparam int SCALE_W     = WORD_W - 1;
  localparam int SQ_W        = 2 * WORD_W;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int NUM1_W      = WORD_W + NQ;
  localparam int Q1_W        = NQ + 1;
  localparam int NORM_W      = NQ + 2;
  localparam int TR_W        = NORM_W + 2;
  localparam int D_W         = NORM_W + 1;
  localparam int DMAG_W      = D_W - 1;
  localparam int NUM2_W      = DMAG_W + FRAC_BITS;
  localparam int H_W         = ROOT_W - 1;
  localparam int DEN2_W      = H_W + 2;
  localparam int Q2_W        = FRAC_BITS + 1;
  localparam int HQ_W        = H_W - (NQ - FRAC_BITS);
  localparam int QUEUE_DEPTH = 4;
  localparam int IN_DATA_W   = 12 * WORD_W;
  localparam int OUT_FIELD_W = N_AXIS * SCALE_W + 7 * WORD_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Which quaternion component comes from the root of the largest trace term.
  typedef enum logic [3:0] {
    SEL_W = 4'b0001,
    SEL_X = 4'b0010,
    SEL_Y = 4'b0100,
    SEL_Z = 4'b1000
  } sel_t;

  typedef struct packed {
    logic [N_AXIS-1:0][SCALE_W-1:0] scale;
    logic [N_AXIS-1:0][WORD_W-1:0]  trans;
    logic                           degen;
  } pass_t;

  typedef struct packed {
    logic [N_ELEM-1:0][NORM_W-1:0] n;
    pass_t                         pass;
  } norm_item_t;

endpackage

/* design/atd_sqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage, several lanes.
module atd_sqrt_pipe #(
  parameter int LANES  = 1,
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [LANES-1:0][IN_W-1:0]       in_val,
  input  logic [SIDE_W-1:0]                side_in,
  output logic                             out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]     out_root,
  output logic [SIDE_W-1:0]                side_out
);

  localparam int ROOT_W = IN_W / 2;

  logic [LANES-1:0][IN_W-1:0] rem_r  [ROOT_W];
  logic [LANES-1:0][IN_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0]          side_r [ROOT_W];
  logic                       vld_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int SH = 2 * (ROOT_W - 1 - k);
    localparam logic [IN_W:0] BIT = (IN_W + 1)'(1) << SH;

    logic [LANES-1:0][IN_W-1:0] v_in, r_in, v_nxt, r_nxt;
    logic [LANES-1:0][IN_W:0]   trial;
    logic                       vld_in;
    logic [SIDE_W-1:0]          side_s;

    if (k == 0) begin : g_first
      assign v_in   = in_val;
      assign r_in   = '0;
      assign vld_in = in_valid;
      assign side_s = side_in;
    end else begin : g_next
      assign v_in   = rem_r[k-1];
      assign r_in   = root_r[k-1];
      assign vld_in = vld_r[k-1];
      assign side_s = side_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {1'b0, r_in[l]} + BIT;
        if ({1'b0, v_in[l]} >= trial[l]) begin
          v_nxt[l] = v_in[l] - trial[l][IN_W-1:0];
          r_nxt[l] = (r_in[l] >> 1) + BIT[IN_W-1:0];
        end else begin
          v_nxt[l] = v_in[l];
          r_nxt[l] = r_in[l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= v_nxt;
        root_r[k] <= r_nxt;
        side_r[k] <= side_s;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_root[l] = root_r[ROOT_W-1][l][ROOT_W-1:0];
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign side_out  = side_r[ROOT_W-1];

endmodule

/* design/atd_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module atd_div_pipe #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  input  logic [LANES-1:0][DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic [LANES-1:0][Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0]            side_out
);

  // The quotient is known to fit in Q_W bits, so the remainder always
  // stays below the divisor shifted by Q_W.
  localparam int W = DEN_W + Q_W;

  logic [LANES-1:0][NUM_W-1:0] rem_r [Q_W];
  logic [LANES-1:0][DEN_W-1:0] den_r [Q_W];
  logic [LANES-1:0][Q_W-1:0]   quo_r [Q_W];
  logic [SIDE_W-1:0]           side_r [Q_W];
  logic                        vld_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int J = Q_W - 1 - k;

    logic [LANES-1:0][NUM_W-1:0] n_in, n_nxt;
    logic [LANES-1:0][DEN_W-1:0] d_in;
    logic [LANES-1:0][Q_W-1:0]   q_in, q_nxt;
    logic [LANES-1:0][W-1:0]     shifted;
    logic                        vld_in;
    logic [SIDE_W-1:0]           side_s;

    if (k == 0) begin : g_first
      assign n_in   = in_num;
      assign d_in   = in_den;
      assign q_in   = '0;
      assign vld_in = in_valid;
      assign side_s = side_in;
    end else begin : g_next
      assign n_in   = rem_r[k-1];
      assign d_in   = den_r[k-1];
      assign q_in   = quo_r[k-1];
      assign vld_in = vld_r[k-1];
      assign side_s = side_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        shifted[l] = W'(d_in[l]) << J;
        q_nxt[l]   = q_in[l];
        if (W'(n_in[l]) >= shifted[l]) begin
          n_nxt[l]    = n_in[l] - shifted[l][NUM_W-1:0];
          q_nxt[l][J] = 1'b1;
        end else begin
          n_nxt[l] = n_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= n_nxt;
        den_r[k]  <= d_in;
        quo_r[k]  <= q_nxt;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign side_out  = side_r[Q_W-1];

endmodule

/* design/atd_front.sv */
// Front part: row norms, scale roots and row normalization.
module atd_front
  import atd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [N_ELEM-1:0][WORD_W-1:0] in_m,
  input  logic [N_AXIS-1:0][WORD_W-1:0] in_trans,
  output logic                          out_valid,
  input  logic                          out_ready,
  output norm_item_t                    out_item
);

  typedef struct packed {
    logic [N_ELEM-1:0][WORD_W-1:0] m;
    logic [N_AXIS-1:0][WORD_W-1:0] trans;
  } root_side_t;

  typedef struct packed {
    logic [N_ELEM-1:0] neg;
    pass_t             pass;
  } div_side_t;

  logic adv;

  logic                          vld_a_r, vld_b_r, vld_c_r;
  logic [N_ELEM-1:0][WORD_W-1:0] m_a_r, m_b_r, m_c_r;
  logic [N_AXIS-1:0][WORD_W-1:0] tr_a_r, tr_b_r, tr_c_r;
  logic [N_ELEM-1:0][SQ_W-1:0]   sq_b_r;
  logic [N_AXIS-1:0][SQ_W-1:0]   sum_c_r;
  logic [N_ELEM-1:0][WORD_W-1:0] mag_a;

  root_side_t                    rs_in, rs_out;
  logic                          root_valid;
  logic [N_AXIS-1:0][ROOT_W-1:0] root;

  logic [N_ELEM-1:0][NUM1_W-1:0] num;
  logic [N_ELEM-1:0][ROOT_W-1:0] den;
  div_side_t                     ds_in, ds_out;
  logic                          div_valid;
  logic [N_ELEM-1:0][Q1_W-1:0]   quo;

  // The whole front advances together unless the queue is full.
  assign adv      = !div_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    for (int e = 0; e < N_ELEM; e++) begin
      mag_a[e] = m_a_r[e][WORD_W-1] ? (WORD_W'(0) - m_a_r[e]) : m_a_r[e];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a_r  <= in_m;
      tr_a_r <= in_trans;
      for (int e = 0; e < N_ELEM; e++) begin
        sq_b_r[e] <= SQ_W'(mag_a[e]) * SQ_W'(mag_a[e]);
      end
      m_b_r  <= m_a_r;
      tr_b_r <= tr_a_r;
      for (int a = 0; a < N_AXIS; a++) begin
        sum_c_r[a] <= sq_b_r[3*a] + sq_b_r[3*a+1] + sq_b_r[3*a+2];
      end
      m_c_r  <= m_b_r;
      tr_c_r <= tr_b_r;
    end
  end

  assign rs_in.m     = m_c_r;
  assign rs_in.trans = tr_c_r;

  atd_sqrt_pipe #(
    .LANES  (N_AXIS),
    .IN_W   (SQ_W),
    .SIDE_W ($bits(root_side_t))
  ) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vld_c_r),
    .in_val    (sum_c_r),
    .side_in   (rs_in),
    .out_valid (root_valid),
    .out_root  (root),
    .side_out  (rs_out)
  );

  always_comb begin
    ds_in.pass.degen = 1'b0;
    for (int a = 0; a < N_AXIS; a++) begin
      if (root[a] == '0) begin
        ds_in.pass.degen = 1'b1;
      end
      // Roots above the field range saturate in the scale field; the divisor takes the full root.
      ds_in.pass.scale[a] = root[a][ROOT_W-1] ? {SCALE_W{1'b1}} : root[a][SCALE_W-1:0];
    end
    ds_in.pass.trans = rs_out.trans;
    for (int e = 0; e < N_ELEM; e++) begin
      ds_in.neg[e] = rs_out.m[e][WORD_W-1];
      num[e] = {(rs_out.m[e][WORD_W-1] ? (WORD_W'(0) - rs_out.m[e]) : rs_out.m[e]),
                {NQ{1'b0}}};
      den[e] = root[e / N_AXIS];
    end
  end

  atd_div_pipe #(
    .LANES  (N_ELEM),
    .NUM_W  (NUM1_W),
    .DEN_W  (ROOT_W),
    .Q_W    (Q1_W),
    .SIDE_W ($bits(div_side_t))
  ) u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (root_valid),
    .in_num    (num),
    .in_den    (den),
    .side_in   (ds_in),
    .out_valid (div_valid),
    .out_quo   (quo),
    .side_out  (ds_out)
  );

  always_comb begin
    out_item.pass = ds_out.pass;
    for (int e = 0; e < N_ELEM; e++) begin
      out_item.n[e] = ds_out.neg[e] ? (NORM_W'(0) - NORM_W'(quo[e])) : NORM_W'(quo[e]);
    end
  end

  assign out_valid = div_valid;

endmodule

/* design/atd_queue.sv */
// Short queue between the front and back parts.
module atd_queue
  `include "affine_trs_decompose_top_macros.svh"
  import atd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int W     = $bits(norm_item_t)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = cnt_r != CNT_FULL;
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ATD_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_FULL, "queue count beyond depth")
  `ATD_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, pop_valid, "queue empty after push")

endmodule

/* design/atd_back.sv */
// Back part: trace terms, quaternion root, ratios and the output register.
module atd_back
  `include "affine_trs_decompose_top_macros.svh"
  import atd_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  norm_item_t                     in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [N_AXIS-1:0][SCALE_W-1:0] out_scale,
  output logic [N_AXIS-1:0][WORD_W-1:0]  out_trans,
  output logic [3:0][WORD_W-1:0]         out_quat,
  output logic                           out_degen
);

  typedef struct packed {
    logic [2:0][D_W-1:0] d;
    sel_t                sel;
    pass_t               pass;
  } root_side_t;

  typedef struct packed {
    logic [2:0]      neg;
    logic [HQ_W-1:0] hq;
    sel_t            sel;
    pass_t           pass;
  } div_side_t;

  logic adv;

  // Stage A: trace terms and the six pair terms.
  logic                          vld_a_r;
  logic signed [TR_W-1:0]        tw_a_r, tx_a_r, ty_a_r, tz_a_r;
  logic signed [D_W-1:0]         pa_a_r, pb_a_r, pc_a_r, pp_a_r, pq_a_r, pr_a_r;
  pass_t                         pass_a_r;
  logic signed [N_ELEM-1:0][TR_W-1:0] nt;

  // Stage B: selected term and root operand.
  logic                          vld_b_r;
  logic [SQ_W-1:0]               val_b_r;
  root_side_t                    side_b_r;
  logic signed [TR_W-1:0]        best;
  sel_t                          sel;
  logic [2:0][D_W-1:0]           dsel;

  logic                          root_valid;
  logic [0:0][ROOT_W-1:0]        root;
  root_side_t                    rs_out;
  logic [H_W-1:0]                h;
  logic [2:0][NUM2_W-1:0]        num;
  logic [2:0][DEN2_W-1:0]        den;
  logic [2:0][DMAG_W-1:0]        dmag;
  div_side_t                     ds_in, ds_out;
  logic                          div_valid;
  logic [2:0][Q2_W-1:0]          quo;

  logic [2:0][WORD_W-1:0]        qv;
  logic [WORD_W-1:0]             hq32;
  logic [3:0][WORD_W-1:0]        quat_nxt;

  logic                          out_valid_r;
  logic [N_AXIS-1:0][SCALE_W-1:0] scale_r;
  logic [N_AXIS-1:0][WORD_W-1:0] trans_r;
  logic [3:0][WORD_W-1:0]        quat_r;
  logic                          degen_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    for (int e = 0; e < N_ELEM; e++) begin
      nt[e] = TR_W'($signed(in_item.n[e]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tw_a_r   <= nt[0] + nt[4] + nt[8];
      tx_a_r   <= nt[0] - nt[4] - nt[8];
      ty_a_r   <= nt[4] - nt[0] - nt[8];
      tz_a_r   <= nt[8] - nt[0] - nt[4];
      pa_a_r   <= D_W'(nt[5] - nt[7]);
      pb_a_r   <= D_W'(nt[6] - nt[2]);
      pc_a_r   <= D_W'(nt[1] - nt[3]);
      pp_a_r   <= D_W'(nt[1] + nt[3]);
      pq_a_r   <= D_W'(nt[6] + nt[2]);
      pr_a_r   <= D_W'(nt[5] + nt[7]);
      pass_a_r <= in_item.pass;
    end
  end

  // Largest trace term; a tie keeps the earlier one.
  always_comb begin
    best = tw_a_r;
    sel  = SEL_W;
    if (tx_a_r > best) begin
      best = tx_a_r;
      sel  = SEL_X;
    end
    if (ty_a_r > best) begin
      best = ty_a_r;
      sel  = SEL_Y;
    end
    if (tz_a_r > best) begin
      best = tz_a_r;
      sel  = SEL_Z;
    end
    if (best < 0) begin
      best = '0;
    end
    // The three ratio terms in x, y, z, w order, skipping the root slot.
    unique case (sel)
      SEL_W:   dsel = {pc_a_r, pb_a_r, pa_a_r};
      SEL_X:   dsel = {pa_a_r, pq_a_r, pp_a_r};
      SEL_Y:   dsel = {pb_a_r, pr_a_r, pp_a_r};
      SEL_Z:   dsel = {pc_a_r, pr_a_r, pq_a_r};
      default: dsel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_b_r       <= SQ_W'($unsigned(best) + (TR_W'(1) << NQ)) << NQ;
      side_b_r.d    <= dsel;
      side_b_r.sel  <= sel;
      side_b_r.pass <= pass_a_r;
    end
  end

  atd_sqrt_pipe #(
    .LANES  (1),
    .IN_W   (SQ_W),
    .SIDE_W ($bits(root_side_t))
  ) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vld_b_r),
    .in_val    (val_b_r),
    .side_in   (side_b_r),
    .out_valid (root_valid),
    .out_root  (root),
    .side_out  (rs_out)
  );

  always_comb begin
    h         = root[0][ROOT_W-1:1];
    ds_in.hq  = h[H_W-1:NQ-FRAC_BITS];
    ds_in.sel = rs_out.sel;
    ds_in.pass = rs_out.pass;
    for (int c = 0; c < 3; c++) begin
      ds_in.neg[c] = rs_out.d[c][D_W-1];
      dmag[c] = rs_out.d[c][D_W-1] ? DMAG_W'(D_W'(0) - rs_out.d[c])
                                   : rs_out.d[c][DMAG_W-1:0];
      num[c]  = {dmag[c], {FRAC_BITS{1'b0}}};
      den[c]  = {h, 2'b00};
    end
  end

  atd_div_pipe #(
    .LANES  (3),
    .NUM_W  (NUM2_W),
    .DEN_W  (DEN2_W),
    .Q_W    (Q2_W),
    .SIDE_W ($bits(div_side_t))
  ) u_ratio_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (root_valid),
    .in_num    (num),
    .in_den    (den),
    .side_in   (ds_in),
    .out_valid (div_valid),
    .out_quo   (quo),
    .side_out  (ds_out)
  );

  // Quaternion components in x, y, z, w order.
  always_comb begin
    hq32 = WORD_W'(ds_out.hq);
    for (int c = 0; c < 3; c++) begin
      qv[c] = ds_out.neg[c] ? (WORD_W'(0) - WORD_W'(quo[c])) : WORD_W'(quo[c]);
    end
    unique case (ds_out.sel)
      SEL_W:   quat_nxt = {hq32, qv[2], qv[1], qv[0]};
      SEL_X:   quat_nxt = {qv[2], qv[1], qv[0], hq32};
      SEL_Y:   quat_nxt = {qv[2], qv[1], hq32, qv[0]};
      SEL_Z:   quat_nxt = {qv[2], hq32, qv[1], qv[0]};
      default: quat_nxt = '0;
    endcase
    if (ds_out.pass.degen) begin
      quat_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scale_r <= ds_out.pass.scale;
      trans_r <= ds_out.pass.trans;
      quat_r  <= quat_nxt;
      degen_r <= ds_out.pass.degen;
    end
  end

  assign out_valid = out_valid_r;
  assign out_scale = scale_r;
  assign out_trans = trans_r;
  assign out_quat  = quat_r;
  assign out_degen = degen_r;

  `ATD_ASSERT_IMPL(a_degen_zero_quat, clk, rst_n, out_valid_r && degen_r, quat_r == '0, "degenerate result with nonzero rotation")
  `ATD_ASSERT_IMPL(a_zero_scale_degen, clk, rst_n, out_valid_r && (scale_r[0] == '0 || scale_r[1] == '0 || scale_r[2] == '0), degen_r, "zero scale without degenerate flag")

endmodule

/* design/affine_trs_decompose_top.sv */
// Throughput: one transform per cycle unless out_tready or a full queue stalls; the front
// root and divider pipelines, a four-entry queue and the back root and divider pipelines
// all take one transaction per cycle, and a full queue stalls only the front.
// Reset: rst_n is synchronous and active low; it clears valid bits and
// queue pointers, and the block is ready in the first cycle after it.
module affine_trs_decompose_top
  import atd_pkg::*;
#(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, trans_in_x, trans_in_y, trans_in_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // scale_x, scale_y, scale_z, trans_x, trans_y, trans_z,
  // quat_x, quat_y, quat_z, quat_w, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic                  out_tuser
);

  logic [N_ELEM-1:0][WORD_W-1:0]  m;
  logic [N_AXIS-1:0][WORD_W-1:0]  trans_in;
  logic                           fr_valid, fr_ready;
  norm_item_t                     fr_item;
  logic                           bk_valid, bk_ready;
  norm_item_t                     bk_item;
  logic [N_AXIS-1:0][SCALE_W-1:0] scale;
  logic [N_AXIS-1:0][WORD_W-1:0]  trans;
  logic [3:0][WORD_W-1:0]         quat;

  always_comb begin
    for (int e = 0; e < N_ELEM; e++) begin
      m[e] = in_tdata[e*WORD_W +: WORD_W];
    end
    for (int a = 0; a < N_AXIS; a++) begin
      trans_in[a] = in_tdata[(N_ELEM+a)*WORD_W +: WORD_W];
    end
  end

  atd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_m      (m),
    .in_trans  (trans_in),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  atd_queue #(
    .DEPTH (Q_DEPTH),
    .W     ($bits(norm_item_t))
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_item)
  );

  atd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bk_valid),
    .in_ready  (bk_ready),
    .in_item   (bk_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_scale (scale),
    .out_trans (trans),
    .out_quat  (quat),
    .out_degen (out_tuser)
  );

  assign out_tdata = {(OUT_DATA_W - OUT_FIELD_W)'(0), quat, trans, scale};

endmodule

/* dv/tb_affine_trs_decompose_top.sv */
// Self-checking testbench for the affine transform decomposition block.
module tb_affine_trs_decompose_top;
  import atd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct {
    logic [SCALE_W-1:0] scale [3];
    word_t              trans [3];
    word_t              quat  [4];  // x, y, z, w
    logic               degen;
  } trs_t;

  localparam longint unsigned SCALE_MAX = (64'd1 << (WORD_W - 1)) - 1;
  localparam longint CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  trs_t   pending_trs [$];
  int     err_count = 0;
  longint cycle = 0;
  int     burst_left = 0;
  bit     valid_hi = 1'b0;
  int     stall_mode = 0;

  affine_trs_decompose_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("[affine_trs_decompose_top] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic word_t clamp_word(longint v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return word_t'(v);
  endfunction

  // Off-axis quaternion component: d / (4h), truncated toward zero.
  function automatic word_t quat_ratio(longint d, longint unsigned h);
    longint q;
    q = longint'((abs64(d) << FRAC_BITS) / (h << 2));
    return clamp_word(d < 0 ? -q : q);
  endfunction

  function automatic trs_t decompose(word_t m [9], word_t t [3]);
    trs_t r;
    longint unsigned s [3];
    longint n [9];
    longint unsigned sum, a, h, hq;
    longint tw, tx, ty, tz, best;
    sel_t sel;
    r.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        a = abs64(longint'(m[i*3+j]));
        sum += a * a;
      end
      s[i] = root64(sum);
      if (s[i] == 0) r.degen = 1'b1;
      r.scale[i] = (s[i] > SCALE_MAX) ? SCALE_MAX[SCALE_W-1:0] : s[i][SCALE_W-1:0];
      r.trans[i] = t[i];
    end
    for (int k = 0; k < 4; k++) r.quat[k] = '0;
    if (!r.degen) begin
      for (int k = 0; k < 9; k++) begin
        a = (abs64(longint'(m[k])) << NQ) / s[k/3];
        n[k] = m[k] < 0 ? -longint'(a) : longint'(a);
      end
      tw = n[0] + n[4] + n[8];
      tx = n[0] - n[4] - n[8];
      ty = n[4] - n[0] - n[8];
      tz = n[8] - n[0] - n[4];
      best = tw;
      sel = SEL_W;
      if (tx > best) begin best = tx; sel = SEL_X; end
      if (ty > best) begin best = ty; sel = SEL_Y; end
      if (tz > best) begin best = tz; sel = SEL_Z; end
      if (best < 0) best = 0;
      h = root64(($unsigned(best) + (64'd1 << NQ)) << NQ) >> 1;
      hq = h >> (NQ - FRAC_BITS);
      if (hq > SCALE_MAX) hq = SCALE_MAX;
      case (sel)
        SEL_W: begin
          r.quat[3] = word_t'(hq);
          r.quat[0] = quat_ratio(n[5] - n[7], h);
          r.quat[1] = quat_ratio(n[6] - n[2], h);
          r.quat[2] = quat_ratio(n[1] - n[3], h);
        end
        SEL_X: begin
          r.quat[3] = quat_ratio(n[5] - n[7], h);
          r.quat[0] = word_t'(hq);
          r.quat[1] = quat_ratio(n[1] + n[3], h);
          r.quat[2] = quat_ratio(n[6] + n[2], h);
        end
        SEL_Y: begin
          r.quat[3] = quat_ratio(n[6] - n[2], h);
          r.quat[0] = quat_ratio(n[1] + n[3], h);
          r.quat[1] = word_t'(hq);
          r.quat[2] = quat_ratio(n[5] + n[7], h);
        end
        default: begin
          r.quat[3] = quat_ratio(n[1] - n[3], h);
          r.quat[0] = quat_ratio(n[6] + n[2], h);
          r.quat[1] = quat_ratio(n[5] + n[7], h);
          r.quat[2] = word_t'(hq);
        end
      endcase
    end
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    err_count++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycle);
  endtask

  // Sends one transform; the valid line stays high across a burst.
  task automatic send_xform(word_t m [9], word_t t [3]);
    logic [IN_DATA_W-1:0] d;
    for (int k = 0; k < 9; k++) d[k*WORD_W +: WORD_W] = m[k];
    for (int k = 0; k < 3; k++) d[(9+k)*WORD_W +: WORD_W] = t[k];
    in_tvalid <= 1'b1;
    valid_hi = 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    pending_trs.push_back(decompose(m, t));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      valid_hi = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain_results();
    if (valid_hi) begin
      in_tvalid <= 1'b0;
      valid_hi = 1'b0;
    end
    while (pending_trs.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern: phases of always ready, random and mostly stalled.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    trs_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_trs.size() == 0) begin
        report("unexpected", 0, 0);
      end else begin
        w = pending_trs.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (out_tdata[i*SCALE_W +: SCALE_W] !== w.scale[i])
            report($sformatf("scale[%0d]", i), out_tdata[i*SCALE_W +: SCALE_W], w.scale[i]);
          if (out_tdata[3*SCALE_W + i*WORD_W +: WORD_W] !== w.trans[i])
            report($sformatf("trans[%0d]", i),
                   out_tdata[3*SCALE_W + i*WORD_W +: WORD_W], w.trans[i]);
        end
        for (int k = 0; k < 4; k++)
          if (out_tdata[3*SCALE_W + (3+k)*WORD_W +: WORD_W] !== w.quat[k])
            report($sformatf("quat[%0d]", k),
                   out_tdata[3*SCALE_W + (3+k)*WORD_W +: WORD_W], w.quat[k]);
        if (out_tuser !== w.degen) report("degenerate", out_tuser, w.degen);
      end
    end
  end

  function automatic word_t rand_word(int kind);
    case (kind)
      0: return word_t'($urandom());
      1: return word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return ($urandom_range(0, 1) ? 32'sh10000 : -32'sh10000)
                      + word_t'($signed($urandom_range(0, 32'h3fff)) - 32'sh1fff);
    endcase
  endfunction

  task automatic test_directed();
    word_t m [9];
    word_t t [3];
    word_t one;
    one = 32'sh10000;
    t = '{32'sh7fffffff, 32'sh80000000, 32'sh0};
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};                send_xform(m, t);
    m = '{one, 0, 0, 0, -one, 0, 0, 0, -one};              send_xform(m, t);
    m = '{-one, 0, 0, 0, one, 0, 0, 0, -one};              send_xform(m, t);
    m = '{-one, 0, 0, 0, -one, 0, 0, 0, one};              send_xform(m, t);
    // Equal trace terms: w must win over x and y.
    m = '{one, 0, 0, 0, one, 0, 0, 0, -one};               send_xform(m, t);
    m = '{0, 0, 0, 0, one, 0, 0, 0, one};                  send_xform(m, t);
    m = '{one, 0, 0, 0, 0, 0, 0, 0, 0};                    send_xform(m, t);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                      send_xform(m, t);
    for (int k = 0; k < 9; k++) m[k] = 32'sh80000000;      send_xform(m, t);
    for (int k = 0; k < 9; k++) m[k] = 32'sh7fffffff;      send_xform(m, t);
    t = '{32'sh1, 32'shffffffff, 32'sh55aa55aa};
    m = '{32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh7fffffff, 0, 1, 1, 1};
    send_xform(m, t);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                      send_xform(m, t);
    m = '{0, one, 0, -one, 0, 0, 0, 0, one};               send_xform(m, t);
    m = '{0, 0, -one, 0, one, 0, one, 0, 0};               send_xform(m, t);
    m = '{3*one, 4*one, 0, 0, 0, 2*one, one, 0, 0};        send_xform(m, t);
  endtask

  task automatic test_random(int count);
    word_t m [9];
    word_t t [3];
    int kind;
    for (int it = 0; it < count; it++) begin
      kind = $urandom_range(0, 2);
      for (int k = 0; k < 9; k++) m[k] = rand_word(kind);
      if (kind == 2) begin
        // Signed permutation with noise, close to a proper or reflected rotation.
        for (int k = 0; k < 9; k++) m[k] = m[k] >>> 10;
        case ($urandom_range(0, 2))
          0: begin m[0] = rand_word(2); m[4] = rand_word(2); m[8] = rand_word(2); end
          1: begin m[1] = rand_word(2); m[5] = rand_word(2); m[6] = rand_word(2); end
          default: begin m[2] = rand_word(2); m[3] = rand_word(2); m[7] = rand_word(2); end
        endcase
      end
      if ($urandom_range(0, 24) == 0) begin
        kind = $urandom_range(0, 2);
        m[kind*3] = 0; m[kind*3+1] = 0; m[kind*3+2] = 0;
      end
      for (int k = 0; k < 3; k++) t[k] = word_t'($urandom());
      send_xform(m, t);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_results();
    test_random(900);
    drain_results();
    test_random(850);
    drain_results();
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("[affine_trs_decompose_top] OK");
    end else begin
      $display("[affine_trs_decompose_top] ERROR");
    end
    $finish;
  end
endmodule
